// ===== rtl/core/bpwc_pkg.sv =====
// Package for the balance PID wheel current controller.
// Holds field widths, register index codes and the milliamp rounding function.
// Depends on nothing.
package bpwc_pkg;

  localparam int unsigned GainW   = 32;
  localparam int unsigned LimitW  = 47;
  localparam int unsigned MaW     = 15;
  localparam int unsigned StampW  = 64;
  localparam int unsigned SampleW = 16;
  localparam int unsigned CurW    = 16;
  localparam int unsigned IntegW  = 48;
  localparam int unsigned DtW     = 17;
  localparam int unsigned MulAW   = 33;
  localparam int unsigned MulBW   = 25;
  localparam int unsigned ProdW   = 58;
  localparam int unsigned MagW    = 79;
  localparam int unsigned TermW   = 51;
  localparam int unsigned AccW    = 53;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned SplitW  = 24;

  // Longest gap between samples that still integrates, in microseconds.
  localparam logic [DtW-1:0]   MaxGapUs        = 17'd100000;
  localparam logic [MaW-1:0]   CurrentLimitRst = 15'd10000;
  // Saturation bound of the integral term, 2^50 in Q16 milliamps.
  localparam logic [TermW-1:0] TermSat         = {1'b1, {(TermW-1){1'b0}}};
  localparam logic [AccW-1:0]  RoundHalf       = AccW'(32768);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROP_GAIN      = 3'd0,
    CFG_INTEGRAL_GAIN  = 3'd1,
    CFG_DERIV_GAIN     = 3'd2,
    CFG_INTEGRAL_LIMIT = 3'd3,
    CFG_CURRENT_LIMIT  = 3'd4,
    CFG_DRIVE_SCALE    = 3'd5,
    CFG_TURN_SCALE     = 3'd6
  } cfg_reg_e;

  // Rounds a Q16 milliamp value half away from zero and clamps it to +/- lim.
  function automatic logic signed [CurW-1:0] to_ma(input logic signed [AccW-1:0] q16,
                                                   input logic [MaW-1:0] lim);
    logic [AccW-1:0] m;
    logic [AccW-1:0] r;
    logic [MaW-1:0]  c;
    m = q16[AccW-1] ? AccW'(-q16) : AccW'(q16);
    r = (m + RoundHalf) >> 16;
    c = (r > AccW'(lim)) ? lim : r[MaW-1:0];
    return q16[AccW-1] ? CurW'(-{1'b0, c}) : CurW'({1'b0, c});
  endfunction

endpackage

// ===== rtl/core/balance_pid_wheel_current.sv =====
// Top level of the balance PID wheel current controller.
// Uses bpwc_pkg for widths, register codes and the rounding function.
// Contains the sequencer, the shared multiplier and the output register.
//
// A user should know this first: every sample request yields exactly one result
// request. A sample that is disabled, stopped, invalid or non-finite goes from
// acceptance straight to the last step, and from there to the output register.
// A computed sample visits every step when it integrates; when the elapsed
// time is zero, missing or too long, the three integrator steps are skipped.
// All products of a sample pass one after another through the single 33 by 25
// bit signed multiplier: pitch times elapsed time when integrating, two halves
// of the integral term, and the proportional, derivative, drive and turn
// products. Each product is registered before it is summed. The block takes no
// new sample while one is in work. It does accept the next sample while the
// previous result still waits in the output register. A finished result that
// finds the output register still full holds the sequencer in its last step
// until the consumer takes the waiting request. Configuration writes are taken
// only while no sample is in work.
module balance_pid_wheel_current (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write channel.
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bpwc_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [bpwc_pkg::LimitW-1:0]          cfg_data_i,
  // Sample channel.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 operator_enabled_i,
  input  logic                                 emergency_stop_i,
  input  logic                                 estimate_valid_i,
  input  logic                                 estimate_finite_i,
  input  logic [bpwc_pkg::StampW-1:0]          timestamp_us_i,
  input  logic signed [bpwc_pkg::SampleW-1:0]  pitch_angle_i,
  input  logic signed [bpwc_pkg::SampleW-1:0]  pitch_rate_i,
  input  logic signed [bpwc_pkg::SampleW-1:0]  drive_command_i,
  input  logic signed [bpwc_pkg::SampleW-1:0]  turn_command_i,
  // Result channel.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [bpwc_pkg::CurW-1:0]     left_current_ma_o,
  output logic signed [bpwc_pkg::CurW-1:0]     right_current_ma_o,
  output logic                                 command_valid_o
);
  import bpwc_pkg::*;

  // One-hot sequencer states, in the order a computed sample visits them.
  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_DT   = 15'b000000000000010,
    S_MI   = 15'b000000000000100,
    S_AI   = 15'b000000000001000,
    S_CI   = 15'b000000000010000,
    S_MLO  = 15'b000000000100000,
    S_MHI  = 15'b000000001000000,
    S_MSUM = 15'b000000010000000,
    S_SAT  = 15'b000000100000000,
    S_ACCP = 15'b000001000000000,
    S_ACCD = 15'b000010000000000,
    S_DQ   = 15'b000100000000000,
    S_MIX  = 15'b001000000000000,
    S_RND  = 15'b010000000000000,
    S_DONE = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic signed [GainW-1:0] prop_gain_q, integral_gain_q, deriv_gain_q;
  logic [LimitW-1:0]       integral_limit_q;
  logic [MaW-1:0]          current_limit_q, drive_scale_q, turn_scale_q;

  // Controller state.
  logic signed [IntegW-1:0] integ_q;
  logic [StampW-1:0]        last_stamp_q;

  // Captured sample.
  logic [StampW-1:0]         now_q;
  logic signed [SampleW-1:0] pitch_q, rate_q, drive_q, turn_q;

  // Datapath registers.
  logic [DtW-1:0]           dt_q;
  logic signed [IntegW:0]   isum_q;
  logic signed [ProdW-1:0]  prod_q;
  logic [MagW-1:0]          mag_q;
  logic signed [AccW-1:0]   acc_q, lsum_q, rsum_q;
  logic signed [CurW-1:0]   res_left_q, res_right_q;
  logic                     res_cmd_q;

  // Output register.
  logic                     out_valid_q;
  logic signed [CurW-1:0]   out_left_q, out_right_q;
  logic                     out_cmd_q;

  logic in_accept, cfg_accept, sample_off, out_load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;
  assign sample_off  = !operator_enabled_i || emergency_stop_i || !estimate_valid_i;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Elapsed time since the previous stamp. A missing stamp or time running
  // backwards counts as no elapsed time; no time or a long gap resets the
  // integrator instead of integrating.
  logic [StampW:0] stamp_diff;
  logic            have_prev, integrate;
  assign stamp_diff = {1'b0, now_q} - {1'b0, last_stamp_q};
  assign have_prev  = (last_stamp_q != '0) && !stamp_diff[StampW];
  assign integrate  = have_prev && (stamp_diff[StampW-1:0] != '0) &&
                      (stamp_diff[StampW-1:0] <= StampW'(MaxGapUs));

  // Magnitudes for the integral term, whose product with the gain is too wide
  // for one multiplier pass and is built from two partial products.
  logic [GainW-1:0]  ig_mag;
  logic [IntegW-1:0] is_mag;
  logic              term_neg;
  assign ig_mag   = integral_gain_q[GainW-1] ? GainW'(-integral_gain_q)
                                             : GainW'(integral_gain_q);
  assign is_mag   = integ_q[IntegW-1] ? IntegW'(-integ_q) : IntegW'(integ_q);
  assign term_neg = integral_gain_q[GainW-1] ^ integ_q[IntegW-1];

  logic signed [SampleW:0] neg_rate;
  assign neg_rate = -((SampleW+1)'(rate_q));

  // Shared multiplier: operands chosen by the sequencer state.
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MI: begin
        mul_a = MulAW'(pitch_q);
        mul_b = MulBW'(dt_q);
      end
      S_MLO: begin
        mul_a = MulAW'(ig_mag);
        mul_b = MulBW'(is_mag[SplitW-1:0]);
      end
      S_MHI: begin
        mul_a = MulAW'(ig_mag);
        mul_b = MulBW'(is_mag[LimitW-1:SplitW]);
      end
      S_SAT: begin
        mul_a = MulAW'(prop_gain_q);
        mul_b = MulBW'(pitch_q);
      end
      S_ACCP: begin
        mul_a = MulAW'(deriv_gain_q);
        mul_b = MulBW'(neg_rate);
      end
      S_ACCD: begin
        mul_a = MulAW'(drive_scale_q);
        mul_b = MulBW'(drive_q);
      end
      S_DQ: begin
        mul_a = MulAW'(turn_scale_q);
        mul_b = MulBW'(turn_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Integral term after saturation, and the turn bias in Q16 milliamps.
  logic [TermW-1:0]       sat_term;
  logic signed [AccW-1:0] turn_bias;
  logic signed [IntegW:0] lim_s;
  assign sat_term  = (mag_q > MagW'(TermSat)) ? TermSat : mag_q[TermW-1:0];
  assign turn_bias = AccW'(prod_q) <<< 2;
  assign lim_s     = $signed({2'b00, integral_limit_q});

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = (sample_off || !estimate_finite_i) ? S_DONE : S_DT;
        end
      end
      S_DT:   state_d = integrate ? S_MI : S_MLO;
      S_MI:   state_d = S_AI;
      S_AI:   state_d = S_CI;
      S_CI:   state_d = S_MLO;
      S_MLO:  state_d = S_MHI;
      S_MHI:  state_d = S_MSUM;
      S_MSUM: state_d = S_SAT;
      S_SAT:  state_d = S_ACCP;
      S_ACCP: state_d = S_ACCD;
      S_ACCD: state_d = S_DQ;
      S_DQ:   state_d = S_MIX;
      S_MIX:  state_d = S_RND;
      S_RND:  state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q      <= '0;
      integral_gain_q  <= '0;
      deriv_gain_q     <= '0;
      integral_limit_q <= '0;
      current_limit_q  <= CurrentLimitRst;
      drive_scale_q    <= '0;
      turn_scale_q     <= '0;
    end else if (cfg_accept) begin
      unique case (cfg_index_i)
        CFG_PROP_GAIN:      prop_gain_q      <= $signed(cfg_data_i[GainW-1:0]);
        CFG_INTEGRAL_GAIN:  integral_gain_q  <= $signed(cfg_data_i[GainW-1:0]);
        CFG_DERIV_GAIN:     deriv_gain_q     <= $signed(cfg_data_i[GainW-1:0]);
        CFG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data_i;
        CFG_CURRENT_LIMIT:  current_limit_q  <= cfg_data_i[MaW-1:0];
        CFG_DRIVE_SCALE:    drive_scale_q    <= cfg_data_i[MaW-1:0];
        CFG_TURN_SCALE:     turn_scale_q     <= cfg_data_i[MaW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Integrator and last stamp.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q      <= '0;
      last_stamp_q <= '0;
    end else begin
      if (in_accept && sample_off) begin
        // A disabled, stopped or invalid sample forgets all history.
        integ_q      <= '0;
        last_stamp_q <= '0;
      end else if (state_q == S_DT) begin
        last_stamp_q <= now_q;
        if (!integrate) begin
          integ_q <= '0;
        end
      end else if (state_q == S_CI) begin
        if (isum_q > lim_s) begin
          integ_q <= IntegW'(lim_s);
        end else if (isum_q < -lim_s) begin
          integ_q <= IntegW'(-lim_s);
        end else begin
          integ_q <= isum_q[IntegW-1:0];
        end
      end
    end
  end

  // Sample capture and datapath.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (in_accept) begin
      now_q       <= timestamp_us_i;
      pitch_q     <= pitch_angle_i;
      rate_q      <= pitch_rate_i;
      drive_q     <= drive_command_i;
      turn_q      <= turn_command_i;
      res_left_q  <= '0;
      res_right_q <= '0;
      res_cmd_q   <= 1'b0;
    end
    unique case (state_q)
      S_DT:   dt_q   <= stamp_diff[DtW-1:0];
      S_AI:   isum_q <= (IntegW+1)'(integ_q) + (IntegW+1)'(prod_q);
      S_MHI:  mag_q  <= MagW'(prod_q);
      S_MSUM: mag_q  <= mag_q + (MagW'(prod_q) << SplitW);
      S_SAT:  acc_q  <= term_neg ? -AccW'(sat_term) : AccW'(sat_term);
      S_ACCP: acc_q  <= acc_q + AccW'(prod_q);
      S_ACCD: acc_q  <= acc_q + AccW'(prod_q);
      S_DQ:   acc_q  <= acc_q + (AccW'(prod_q) <<< 2);
      S_MIX: begin
        lsum_q <= acc_q + turn_bias;
        rsum_q <= acc_q - turn_bias;
      end
      S_RND: begin
        res_left_q  <= to_ma(lsum_q, current_limit_q);
        res_right_q <= to_ma(rsum_q, current_limit_q);
        res_cmd_q   <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output register: holds a result until the consumer takes the request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_left_q  <= res_left_q;
      out_right_q <= res_right_q;
      out_cmd_q   <= res_cmd_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign left_current_ma_o  = out_left_q;
  assign right_current_ma_o = out_right_q;
  assign command_valid_o    = out_cmd_q;

  // The integrator is within its limit whenever the integral term is formed.
  a_integ_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MLO) |-> (((IntegW+1)'(integ_q) <= lim_s) &&
                            ((IntegW+1)'(integ_q) >= -lim_s)))
    else $error("integrator outside its limit");

  // A sample that is switched off clears the history in the next cycle.
  a_off_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && sample_off) |=> ((integ_q == '0) && (last_stamp_q == '0)))
    else $error("history not cleared by a disabled sample");

  // An accepted sample always starts work.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q != S_IDLE))
    else $error("sequencer stayed idle after a request");

  // A result without computed currents carries zero currents.
  a_zero_when_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !command_valid_o) |->
      ((left_current_ma_o == '0) && (right_current_ma_o == '0)))
    else $error("nonzero current on an uncomputed result");

endmodule

// ===== tb/sv/tb_balance_pid_wheel_current.sv =====
// Self-checking testbench for the balance PID wheel current controller.
// Needs bpwc_pkg and balance_pid_wheel_current; it predicts every result
// request from its own model of the integrator and the current mixer.
module tb_balance_pid_wheel_current;
  timeunit 1ns;
  timeprecision 1ps;

  import bpwc_pkg::*;

  // Flag patterns of a sample: {operator_enabled, emergency_stop,
  // estimate_valid, estimate_finite}.
  localparam logic [3:0] RunFlags       = 4'b1011;
  localparam logic [3:0] DisabledFlags  = 4'b0011;
  localparam logic [3:0] StoppedFlags   = 4'b1111;
  localparam logic [3:0] InvalidFlags   = 4'b1001;
  localparam logic [3:0] NonFiniteFlags = 4'b1010;

  localparam longint GapLimitUs  = 100000;
  localparam logic [63:0] TermBound = 64'd1 << 50;
  localparam int IdlePct      = 23;
  // Sample and result counts between which neither side idles.
  localparam int SteadyFrom   = 300;
  localparam int SteadyTo     = 450;
  // The receiver holds off once, after this many results, for HoldCycles.
  localparam int HoldAt       = 520;
  localparam int HoldCycles   = 100;
  localparam int SettleCycles = 24;
  localparam int StallLimit   = 3000;
  localparam int ReportMax    = 10;
  localparam int PhaseItems   = 88;

  typedef enum int {SET_TYPICAL, SET_MAX, SET_MIN, SET_RAW, SET_TIGHT} setting_e;

  typedef struct packed {
    logic               enabled;
    logic               estop;
    logic               est_valid;
    logic               est_finite;
    logic [StampW-1:0]  stamp;
    logic [SampleW-1:0] pitch;
    logic [SampleW-1:0] rate;
    logic [SampleW-1:0] drive;
    logic [SampleW-1:0] turn;
  } sample_t;

  typedef struct packed {
    logic [CurW-1:0] left_ma;
    logic [CurW-1:0] right_ma;
    logic            computed;
  } wheel_cmd_t;

  // Block ports. Every input starts at a known value.
  logic                   clk_i              = 1'b0;
  logic                   rst_ni             = 1'b0;
  logic                   cfg_valid_i        = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxW-1:0]     cfg_index_i        = '0;
  logic [LimitW-1:0]      cfg_data_i         = '0;
  logic                   in_valid_i         = 1'b0;
  logic                   in_ready_o;
  logic                   operator_enabled_i = 1'b0;
  logic                   emergency_stop_i   = 1'b0;
  logic                   estimate_valid_i   = 1'b0;
  logic                   estimate_finite_i  = 1'b0;
  logic [StampW-1:0]      timestamp_us_i     = '0;
  logic [SampleW-1:0]     pitch_angle_i      = '0;
  logic [SampleW-1:0]     pitch_rate_i       = '0;
  logic [SampleW-1:0]     drive_command_i    = '0;
  logic [SampleW-1:0]     turn_command_i     = '0;
  logic                   out_valid_o;
  logic                   out_ready_i        = 1'b0;
  logic [CurW-1:0]        left_current_ma_o;
  logic [CurW-1:0]        right_current_ma_o;
  logic                   command_valid_o;

  // Predictor copy of the registers and of the controller state.
  longint      kp        = 0;
  longint      ki        = 0;
  longint      kd        = 0;
  longint      integ_lim = 0;
  longint      cur_lim   = 10000;
  longint      drv_scale = 0;
  longint      trn_scale = 0;
  longint      integ_acc = 0;
  logic [63:0] prev_stamp = '0;

  sample_t    pending_q[$];    // samples waiting to be offered
  wheel_cmd_t wheel_cmd_q[$];  // predicted wheel commands, oldest first
  sample_t    cur_sample;      // sample currently offered on the input
  logic [63:0] gen_stamp = '0; // running timestamp of the generator
  int pushed_n = 0;
  int sent_n   = 0;
  int result_n = 0;
  int fail_n   = 0;

  always #4 clk_i = ~clk_i;

  balance_pid_wheel_current u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .operator_enabled_i (operator_enabled_i),
    .emergency_stop_i   (emergency_stop_i),
    .estimate_valid_i   (estimate_valid_i),
    .estimate_finite_i  (estimate_finite_i),
    .timestamp_us_i     (timestamp_us_i),
    .pitch_angle_i      (pitch_angle_i),
    .pitch_rate_i       (pitch_rate_i),
    .drive_command_i    (drive_command_i),
    .turn_command_i     (turn_command_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .left_current_ma_o  (left_current_ma_o),
    .right_current_ma_o (right_current_ma_o),
    .command_valid_o    (command_valid_o)
  );

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Mirrors one register write; narrow registers keep only their low bits.
  function automatic void store_setting(cfg_reg_e idx, logic [LimitW-1:0] v);
    case (idx)
      CFG_PROP_GAIN:      kp        = longint'($signed(v[31:0]));
      CFG_INTEGRAL_GAIN:  ki        = longint'($signed(v[31:0]));
      CFG_DERIV_GAIN:     kd        = longint'($signed(v[31:0]));
      CFG_INTEGRAL_LIMIT: integ_lim = longint'(v);
      CFG_CURRENT_LIMIT:  cur_lim   = longint'(v[14:0]);
      CFG_DRIVE_SCALE:    drv_scale = longint'(v[14:0]);
      CFG_TURN_SCALE:     trn_scale = longint'(v[14:0]);
      default: ;
    endcase
  endfunction

  // Integral gain times integrator, saturated at +/- 2^50 in Q16 milliamps.
  // Magnitudes are compared by division so the full product never overflows.
  function automatic longint sat_integral_term(longint gain, longint acc);
    logic [63:0] mg;
    logic [63:0] ma;
    logic        neg;
    mg  = (gain < 0) ? -gain : gain;
    ma  = (acc < 0) ? -acc : acc;
    neg = (gain < 0) != (acc < 0);
    if (ma != 0 && mg > TermBound / ma)
      return neg ? -longint'(TermBound) : longint'(TermBound);
    return neg ? -longint'(mg * ma) : longint'(mg * ma);
  endfunction

  // Rounds Q16 milliamps half away from zero and clamps to the current limit.
  function automatic logic [CurW-1:0] round_to_ma(longint q16);
    logic [63:0]     mag;
    logic [CurW-1:0] res;
    mag = (q16 < 0) ? -q16 : q16;
    mag = (mag + 64'd32768) >> 16;
    if (mag > 64'(cur_lim))
      mag = 64'(cur_lim);
    res = mag[CurW-1:0];
    if (q16 < 0)
      res = -res;
    return res;
  endfunction

  // Advances the integrator state for one accepted sample and returns the
  // wheel command that the block must produce for it.
  function automatic wheel_cmd_t compute_wheel_cmd(sample_t s);
    wheel_cmd_t  r;
    longint      pitch;
    longint      rate;
    longint      drive;
    longint      turn;
    longint      base;
    longint      drive_q;
    longint      turn_q;
    logic [63:0] dt;
    r = '0;
    // Missing operator, stop or invalid estimate wipe the integrator history.
    if (!s.enabled || s.estop || !s.est_valid) begin
      integ_acc  = 0;
      prev_stamp = '0;
      return r;
    end
    // A non-finite estimate is ignored entirely.
    if (!s.est_finite)
      return r;
    pitch = longint'($signed(s.pitch));
    rate  = longint'($signed(s.rate));
    drive = longint'($signed(s.drive));
    turn  = longint'($signed(s.turn));
    // Elapsed time needs a stored stamp and must not run backward.
    dt = '0;
    if (prev_stamp != 0 && s.stamp >= prev_stamp)
      dt = s.stamp - prev_stamp;
    if (dt == 0 || dt > 64'(GapLimitUs)) begin
      integ_acc = 0;
      dt        = '0;
    end
    prev_stamp = s.stamp;
    if (dt != 0) begin
      integ_acc = integ_acc + pitch * longint'(dt);
      if (integ_acc > integ_lim)
        integ_acc = integ_lim;
      if (integ_acc < -integ_lim)
        integ_acc = -integ_lim;
    end
    base    = kp * pitch + sat_integral_term(ki, integ_acc) - kd * rate;
    drive_q = drive * drv_scale * 4;
    turn_q  = turn * trn_scale * 4;
    r.left_ma  = round_to_ma(base + drive_q + turn_q);
    r.right_ma = round_to_ma(base + drive_q - turn_q);
    r.computed = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  function automatic void queue_sample(sample_t s);
    pending_q.push_back(s);
    pushed_n++;
  endfunction

  function automatic void queue_directed(logic [3:0] flags, logic [63:0] stamp,
                                         logic [15:0] pitch, logic [15:0] rate,
                                         logic [15:0] drive, logic [15:0] turn);
    sample_t s;
    s.enabled    = flags[3];
    s.estop      = flags[2];
    s.est_valid  = flags[1];
    s.est_finite = flags[0];
    s.stamp      = stamp;
    s.pitch      = pitch;
    s.rate       = rate;
    s.drive      = drive;
    s.turn       = turn;
    queue_sample(s);
  endfunction

  // A fixed-point field: mostly near zero, sometimes any value or an extreme.
  function automatic logic [SampleW-1:0] rand_q(int span);
    int pick;
    logic [SampleW-1:0] v;
    pick = $urandom_range(0, 9);
    if (pick == 0)
      v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    else if (pick < 4)
      v = SampleW'($urandom);
    else
      v = SampleW'(int'($urandom_range(0, 2 * span)) - span);
    return v;
  endfunction

  // Mostly a steady sample stream with short steps in time; now and then a
  // flag drop, a long gap, a repeated or backward stamp, or a jump anywhere.
  function automatic sample_t rand_sample();
    sample_t s;
    int pick;
    s.enabled    = ($urandom_range(0, 99) >= 6);
    s.estop      = ($urandom_range(0, 99) < 4);
    s.est_valid  = ($urandom_range(0, 99) >= 5);
    s.est_finite = ($urandom_range(0, 99) >= 6);
    pick = $urandom_range(0, 99);
    if (pick < 68)
      gen_stamp = gen_stamp + $urandom_range(1, 2000);
    else if (pick < 76)
      gen_stamp = gen_stamp + $urandom_range(2001, 99999);
    else if (pick < 80)
      gen_stamp = gen_stamp + 64'(GapLimitUs) + $urandom_range(0, 1);
    else if (pick < 84)
      gen_stamp = gen_stamp - $urandom_range(1, 5000);
    else if (pick < 87)
      gen_stamp = '0;
    else if (pick < 91)
      gen_stamp = {$urandom, $urandom};
    else if (pick < 95)
      gen_stamp = gen_stamp + ({$urandom, $urandom} >> $urandom_range(17, 63));
    // The remaining picks repeat the previous stamp.
    s.stamp = gen_stamp;
    s.pitch = rand_q(3000);
    s.rate  = rand_q(3000);
    s.drive = rand_q(16384);
    s.turn  = rand_q(16384);
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration and phase control
  // ---------------------------------------------------------------------------

  // One write request on the configuration channel; the predictor takes the
  // value at the edge where the block accepts it.
  task automatic write_reg(cfg_reg_e idx, logic [LimitW-1:0] v);
    @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    store_setting(idx, v);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_setting(setting_e kind);
    logic [LimitW-1:0] v[7];
    case (kind)
      SET_MAX: begin
        v = '{47'(32'h7FFF_FFFF), 47'(32'h7FFF_FFFF), 47'(32'h8000_0000),
              {LimitW{1'b1}}, 47'h7FFF, 47'h7FFF, 47'h7FFF};
      end
      SET_MIN: begin
        v = '{47'(32'h8000_0000), 47'(32'h8000_0000), 47'(32'h7FFF_FFFF),
              '0, '0, '0, '0};
      end
      SET_RAW: begin
        // Every bit random; narrow registers must drop their upper bits.
        foreach (v[i])
          v[i] = LimitW'({$urandom, $urandom});
      end
      SET_TIGHT: begin
        v[0] = LimitW'(int'($urandom_range(0, 4000)) - 2000);
        v[1] = LimitW'(int'($urandom_range(0, 2 << 20)) - (1 << 20));
        v[2] = LimitW'(int'($urandom_range(0, 4000)) - 2000);
        v[3] = LimitW'($urandom_range(1, 1000));
        v[4] = LimitW'($urandom_range(1, 50));
        v[5] = LimitW'($urandom_range(0, 32767));
        v[6] = LimitW'($urandom_range(0, 32767));
      end
      default: begin
        v[0] = LimitW'(int'($urandom_range(0, 60000)) - 30000);
        v[1] = LimitW'(int'($urandom_range(0, 600)) - 300);
        v[2] = LimitW'(int'($urandom_range(0, 60000)) - 30000);
        v[3] = LimitW'($urandom_range(0, 4000000));
        v[4] = LimitW'($urandom_range(500, 32767));
        v[5] = LimitW'($urandom_range(0, 20000));
        v[6] = LimitW'($urandom_range(0, 20000));
      end
    endcase
    write_reg(CFG_PROP_GAIN,      v[0]);
    write_reg(CFG_INTEGRAL_GAIN,  v[1]);
    write_reg(CFG_DERIV_GAIN,     v[2]);
    write_reg(CFG_INTEGRAL_LIMIT, v[3]);
    write_reg(CFG_CURRENT_LIMIT,  v[4]);
    write_reg(CFG_DRIVE_SCALE,    v[5]);
    write_reg(CFG_TURN_SCALE,     v[6]);
  endtask

  // Every sample request yields one result request, so the block is idle once
  // the result count catches up; the extra cycles cover its pipeline.
  task automatic wait_drained();
    while (result_n != pushed_n)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic void note_failure(string msg);
    fail_n++;
    if (fail_n <= ReportMax)
      $display("%s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Sample driver: offers queued samples, holds each one until it is taken,
  // and predicts the result at the edge of acceptance.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : sample_driver
    logic go;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        wheel_cmd_q.push_back(compute_wheel_cmd(cur_sample));
        sent_n++;
      end
      // A sample that is offered and not yet taken stays on the port.
      if (!(in_valid_i && !in_ready_o)) begin
        go = (pending_q.size() != 0) &&
             ((sent_n >= SteadyFrom && sent_n < SteadyTo) ||
              $urandom_range(0, 99) >= IdlePct);
        if (go) begin
          cur_sample = pending_q.pop_front();
          operator_enabled_i <= cur_sample.enabled;
          emergency_stop_i   <= cur_sample.estop;
          estimate_valid_i   <= cur_sample.est_valid;
          estimate_finite_i  <= cur_sample.est_finite;
          timestamp_us_i     <= cur_sample.stamp;
          pitch_angle_i      <= cur_sample.pitch;
          pitch_rate_i       <= cur_sample.rate;
          drive_command_i    <= cur_sample.drive;
          turn_command_i     <= cur_sample.turn;
        end
        in_valid_i <= go;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each accepted result against the oldest prediction
  // and drives out_ready_i, including one long hold-off that backs the block up
  // until it refuses new samples.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    wheel_cmd_t got;
    wheel_cmd_t want;
    logic       rdy;
    int         hold_left;
    logic       held_off;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left = 0;
      held_off  = 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got.left_ma  = left_current_ma_o;
        got.right_ma = right_current_ma_o;
        got.computed = command_valid_o;
        result_n++;
        if (wheel_cmd_q.size() == 0) begin
          note_failure($sformatf("result %0d arrived with no sample pending: %0d %0d %0b",
                                 result_n, $signed(got.left_ma), $signed(got.right_ma),
                                 got.computed));
        end else begin
          want = wheel_cmd_q.pop_front();
          if (got.left_ma !== want.left_ma || got.right_ma !== want.right_ma ||
              got.computed !== want.computed)
            note_failure($sformatf({"result %0d mismatch: expected left %0d right %0d ",
                                    "valid %0b, got left %0d right %0d valid %0b"},
                                   result_n, $signed(want.left_ma), $signed(want.right_ma),
                                   want.computed, $signed(got.left_ma),
                                   $signed(got.right_ma), got.computed));
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!held_off && result_n >= HoldAt) begin
        held_off  = 1'b1;
        hold_left = HoldCycles - 1;
        rdy       = 1'b0;
      end else begin
        rdy = (result_n >= SteadyFrom && result_n < SteadyTo) ||
              $urandom_range(0, 99) >= IdlePct;
      end
      out_ready_i <= rdy;
    end
  end

  // Watchdog: ends the run if no request of any kind moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL balance_pid_wheel_current");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : test_sequence
    setting_e plan[9];
    plan = '{SET_TYPICAL, SET_MAX, SET_TYPICAL, SET_MIN, SET_RAW, SET_TIGHT,
             SET_TYPICAL, SET_RAW, SET_TYPICAL};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Register values straight out of reset: zero gains, 10 A limit.
    gen_stamp = 64'd5000;
    repeat (3) queue_sample(rand_sample());
    wait_drained();

    // Directed samples under a moderate setting.
    program_setting(SET_TYPICAL);
    // First sample has no stored stamp, so nothing integrates.
    queue_directed(RunFlags, 64'd1000, 16'd100, 16'd50, 16'd0, 16'd0);
    queue_directed(RunFlags, 64'd1500, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    queue_directed(RunFlags, 64'd2000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
    // Same stamp twice: zero elapsed time clears the integrator.
    queue_directed(RunFlags, 64'd2000, 16'd500, 16'd0, 16'h8000, 16'h7FFF);
    // A gap of exactly the limit still integrates, one more microsecond clears.
    queue_directed(RunFlags, 64'd102000, 16'h7FFF, 16'd0, 16'd0, 16'd0);
    queue_directed(RunFlags, 64'd202001, 16'h7FFF, 16'd0, 16'd0, 16'd0);
    // Time running backward counts as zero elapsed time.
    queue_directed(RunFlags, 64'd150000, 16'd1000, 16'd10, 16'd0, 16'd0);
    // Non-finite estimate: zero result, integrator and stamp untouched.
    queue_directed(NonFiniteFlags, 64'd150100, 16'h7FFF, 16'h7FFF, 16'd0, 16'd0);
    queue_directed(RunFlags, 64'd150200, 16'd2000, 16'd0, 16'd0, 16'd0);
    // Each way of losing the estimate clears the history.
    queue_directed(DisabledFlags, 64'd150300, 16'd2000, 16'd0, 16'd0, 16'd0);
    queue_directed(RunFlags, 64'd150400, 16'd2000, 16'd0, 16'd0, 16'd0);
    queue_directed(RunFlags, 64'd150500, 16'd2000, 16'd0, 16'd0, 16'd0);
    queue_directed(StoppedFlags, 64'd150600, 16'd2000, 16'd0, 16'd0, 16'd0);
    queue_directed(RunFlags, 64'd150700, 16'd2000, 16'd0, 16'd0, 16'd0);
    queue_directed(InvalidFlags, 64'd150800, 16'd2000, 16'd0, 16'd0, 16'd0);
    // A stamp of zero leaves the next sample without a previous stamp.
    queue_directed(RunFlags, 64'd0, 16'd300, 16'd0, 16'd0, 16'd0);
    queue_directed(RunFlags, 64'd500, 16'd300, 16'd0, 16'd0, 16'd0);
    // Stamps at the top of the range.
    queue_directed(RunFlags, 64'hFFFF_FFFF_FFFF_FFF0, 16'd300, 16'd0, 16'd0, 16'd0);
    queue_directed(RunFlags, 64'hFFFF_FFFF_FFFF_FFFF, 16'h7FFF, 16'd0, 16'd0, 16'd0);
    // Drive the integrator into both clamps.
    queue_directed(RunFlags, 64'd1000, 16'h7FFF, 16'd0, 16'd0, 16'd0);
    queue_directed(RunFlags, 64'd101000, 16'h7FFF, 16'd0, 16'd0, 16'd0);
    queue_directed(RunFlags, 64'd201000, 16'h7FFF, 16'd0, 16'd0, 16'd0);
    queue_directed(RunFlags, 64'd301000, 16'h8000, 16'h8000, 16'd0, 16'd0);
    queue_directed(RunFlags, 64'd401000, 16'h8000, 16'h8000, 16'd0, 16'd0);
    wait_drained();

    // Random phases, each under its own register setting.
    foreach (plan[p]) begin
      program_setting(plan[p]);
      gen_stamp = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'($urandom);
      repeat (PhaseItems) queue_sample(rand_sample());
      wait_drained();
    end

    if (fail_n == 0 && wheel_cmd_q.size() == 0) begin
      $display("PASS balance_pid_wheel_current");
    end else begin
      if (wheel_cmd_q.size() != 0)
        $display("%0d predicted results never arrived", wheel_cmd_q.size());
      $display("FAIL balance_pid_wheel_current");
    end
    $finish;
  end

endmodule
